// ===== design/assert_macros.svh =====
// Assertion macros shared by the list store RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define PLST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define PLST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/plst_pkg.sv =====
// Package for the positional list store: request types, command codes,
// per-cell control struct. No dependencies.
package plst_pkg;

    localparam int DATA_W  = 32;
    localparam int TGT_W   = 7;   // wide enough for any cell index

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [7:0]        position;
        logic signed [DATA_W-1:0] value;
    } cmd_req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [4:0]               entry_count;
    } res_req_t;

    // Broadcast to every cell for one accepted command.
    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic             get_en;
        logic [TGT_W-1:0] tgt;
    } cell_ctrl_t;

endpackage

// ===== design/plst_cell.sv =====
// One storage cell of the list: holds one entry, shifts with its neighbors.
// Depends on plst_pkg.
module plst_cell
    import plst_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] word,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    input  logic [DATA_W-1:0] rd_in,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_out
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (ctrl.tgt == TGT_W'(IDX));
    assign above = (TGT_W'(IDX) > ctrl.tgt);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (hit)
                data_next = word;
            else if (above)
                data_next = prev_data;
        end
        else if (ctrl.rem_en && (hit || above))
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Read chain: the addressed cell drops its word onto the chain.
    assign rd_out = rd_in | ((ctrl.get_en && hit) ? data_reg : '0);
    assign data   = data_reg;

endmodule

// ===== design/positional_list_store_unit.sv =====
// Top level of the positional list store: command decode, count register,
// cell chain and result register. Depends on plst_pkg, plst_cell, assert_macros.svh.
//
// Channel | Direction | Payload    | Handshake
// cmd     | in        | cmd_req_t  | cmd_valid / cmd_stall
// res     | out       | res_req_t  | res_valid / res_stall
//
// Every command takes effect at its accepting edge: the cell chain shifts, loads
// or reads, and the result register holds the response next cycle.
// Throughput is one command per cycle while cmd_stall is low; the result register is the only stage.
// cmd_stall rises only while a result is held and res_stall is high.
// Reset empties the list (count to zero); entry words are not reset.
`include "assert_macros.svh"
module positional_list_store_unit
    import plst_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  cmd_req_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output res_req_t res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    res_req_t         res_reg;
    res_req_t         res_next;

    logic             accept;
    logic             neg;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             in_range;
    cell_ctrl_t       ctrl;
    logic             ok;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] rd_chain  [CAPACITY+1];

    // Output register parts the two sides; a free slot or a draining one
    // lets the next command in.
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign neg      = cmd.position[7];
    assign pos_ext  = CMP_W'(cmd.position[6:0]);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign in_range = !neg && (pos_ext < cnt_ext);

    always_comb
    begin
        ctrl       = '0;
        ok         = 1'b0;
        count_next = count_reg;
        // insert past the end appends at the current count
        ctrl.tgt   = (pos_ext > cnt_ext) ? TGT_W'(cnt_ext) : TGT_W'(pos_ext);
        unique case (cmd_t'(cmd.command))
            CMD_INSERT:
            begin
                if (!neg && !full)
                begin
                    ctrl.ins_en = accept;
                    ok          = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    ctrl.rem_en = accept;
                    ok          = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_GET:
            begin
                ctrl.get_en = in_range;
                ok          = in_range;
            end
            CMD_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Cell chain: cell i takes from i-1 on insert and from i+1 on remove.
    assign rd_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_d = cell_data[gi];
            end
            else
            begin : g_mid_next
                assign next_d = cell_data[gi+1];
            end
            plst_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .word      (cmd.value),
                .prev_data (prev_d),
                .next_data (next_d),
                .rd_in     (rd_chain[gi]),
                .data      (cell_data[gi]),
                .rd_out    (rd_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        res_next.ok          = ok;
        res_next.read_value  = rd_chain[CAPACITY];
        res_next.entry_count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `PLST_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PLST_ASSERT(a_fail_no_data, clk, rst_n, (res_valid && !res.ok) |-> (res.read_value == '0), "failed command returned data")
    `PLST_ASSERT(a_clear_empty, clk, rst_n, (accept && (cmd.command == CMD_CLEAR)) |=> (count_reg == '0), "clear left entries")
    `PLST_ASSERT(a_count_step, clk, rst_n, (accept && (cmd.command == CMD_GET)) |=> $stable(count_reg), "get changed count")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for positional_list_store_unit.
// Depends on plst_pkg and the list store RTL; drives directed and random bursty requests and
// checks each response against a shadow list kept inside the bench.
`timescale 1ns / 1ps

module tb_top;
    import plst_pkg::*;

    localparam int CAPACITY  = 16;
    localparam int MAX_SHOWN = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    cmd_req_t cmd       = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    res_req_t res;

    always #5 clk = ~clk;

    positional_list_store_unit #(.CAPACITY(CAPACITY)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // ------------------------------------------------------------------
    // Shadow list: the bench's own copy of the store contents and length.
    // ------------------------------------------------------------------
    logic signed [31:0] list_words [CAPACITY];
    int                 list_len = 0;

    // Applies one accepted request to the shadow list and returns the
    // response the block must give for it.
    function automatic res_req_t apply_list_command(cmd_req_t c);
        res_req_t r;
        int       p;
        int       i;
        r = '0;
        p = $signed(c.position);
        case (cmd_t'(c.command))
            CMD_INSERT:
            begin
                // position past the end appends; a full list refuses
                if (p >= 0 && list_len < CAPACITY)
                begin
                    if (p > list_len)
                        p = list_len;
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = c.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (p >= 0 && p < list_len)
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (p >= 0 && p < list_len)
                begin
                    r.read_value = list_words[p];
                    r.ok         = 1'b1;
                end
            end
            default:
            begin
                list_len = 0;
                r.ok     = 1'b1;
            end
        endcase
        r.entry_count = 5'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by the processes below.
    // ------------------------------------------------------------------
    cmd_req_t cmd_backlog[$];      // requests waiting for the driver
    res_req_t expected_results[$]; // responses owed by the block, oldest first
    int       issued_cnt   = 0;    // requests put on the bus by the driver
    int       taken_cnt    = 0;    // requests accepted by the block
    int       checked_cnt  = 0;
    int       failures     = 0;
    int       full_rejects = 0;
    int       peak_len     = 0;
    int       op_seen [4]  = '{default: 0};

    task automatic note_failure(string msg);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents requests at the falling edge in bursts with random
    // gaps. Valid is decided from the backlog and burst state only; a request
    // on the bus is held unchanged until the block takes it.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        cmd_req_t nxt_cmd;
        logic     nxt_valid;
        nxt_cmd   = cmd;
        nxt_valid = cmd_valid;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (!cmd_valid || issued_cnt == taken_cnt)
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (cmd_backlog.size() > 0)
            begin
                nxt_cmd   = cmd_backlog.pop_front();
                nxt_valid = 1'b1;
                issued_cnt++;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    // mix of back-to-back stretches and short idle spells
                    if ($urandom_range(0, 4) == 0)
                    begin
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 25);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        cmd       <= nxt_cmd;
        cmd_valid <= nxt_valid;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls in randomly chosen modes, each held for a random stretch, plus two
    // long hold-offs that let the block back up and stall its request side.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int rx_cycle   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            rx_cycle++;
            if (hold_left == 0 && holds_done < 2 && taken_cnt >= (holds_done + 1) * 350)
            begin
                hold_left = 90;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 99) < 30);
                    2:       res_stall <= (rx_cycle % 3 == 0);
                    default: res_stall <= ($urandom_range(0, 99) < 70);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predicts every accepted request, then
    // checks every accepted response against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_req_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_t'(cmd.command) == CMD_INSERT && list_len == CAPACITY)
                    full_rejects++;
                op_seen[cmd.command]++;
                expected_results.push_back(apply_list_command(cmd));
                if (list_len > peak_len)
                    peak_len = list_len;
                taken_cnt++;
            end
            if (res_valid && !res_stall)
            begin
                checked_cnt++;
                if (expected_results.size() == 0)
                    note_failure($sformatf("response with nothing outstanding: ok=%0b rd=%0d cnt=%0d",
                                           res.ok, res.read_value, res.entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    if (res.ok !== want.ok || res.read_value !== want.read_value ||
                        res.entry_count !== want.entry_count)
                        note_failure($sformatf(
                            "response %0d: expected ok=%0b rd=%0d cnt=%0d, got ok=%0b rd=%0d cnt=%0d",
                            checked_cnt, want.ok, want.read_value, want.entry_count,
                            res.ok, res.read_value, res.entry_count));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. gen_len follows the list length as the requests are written
    // so that random positions land mostly inside or just past the list.
    // ------------------------------------------------------------------
    int gen_len   = 0;
    int gen_total = 0;

    task automatic queue_request(cmd_t op, int pos, logic [31:0] val);
        cmd_req_t c;
        c.command  = op;
        c.position = 8'(pos);
        c.value    = val;
        cmd_backlog.push_back(c);
        gen_total++;
        case (op)
            CMD_INSERT: if (pos >= 0 && pos <= 127 && gen_len < CAPACITY) gen_len++;
            CMD_REMOVE: if (pos >= 0 && pos <= 127 && pos < gen_len) gen_len--;
            CMD_CLEAR:  gen_len = 0;
            default:    ;
        endcase
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || issued_cnt != taken_cnt ||
               expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_position();
        // mostly meaningful positions, sometimes anything the field holds
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 255) - 128;
        return $urandom_range(0, gen_len + 2);
    endfunction

    initial
    begin
        int    seg_kind;
        int    seg_items;
        int    next_pause;
        int    roll;
        cmd_t  op;

        // Directed: empty-list failures, append past the end, negative
        // positions, field extremes, every command.
        queue_request(CMD_GET,     0,    32'h0);
        queue_request(CMD_REMOVE,  0,    32'h0);
        queue_request(CMD_INSERT,  5,    32'h1234_5678);  // append into empty list
        queue_request(CMD_INSERT,  -128, 32'hDEAD_BEEF);  // negative, rejected
        queue_request(CMD_GET,     -1,   32'h0);
        queue_request(CMD_REMOVE,  -128, 32'h0);
        queue_request(CMD_INSERT,  0,    32'h8000_0000);
        queue_request(CMD_INSERT,  127,  32'h7FFF_FFFF);
        queue_request(CMD_INSERT,  1,    32'hFFFF_FFFF);
        queue_request(CMD_GET,     0,    32'hFFFF_FFFF);  // value ignored
        queue_request(CMD_GET,     1,    32'h0);
        queue_request(CMD_GET,     3,    32'h0);
        queue_request(CMD_GET,     127,  32'h0);
        queue_request(CMD_REMOVE,  1,    32'h0);
        queue_request(CMD_GET,     1,    32'h0);
        queue_request(CMD_REMOVE,  127,  32'h0);
        queue_request(CMD_CLEAR,   -1,   32'h5555_AAAA);
        queue_request(CMD_GET,     0,    32'h0);
        queue_request(CMD_CLEAR,   0,    32'h0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random: fill, drain, mixed and noise stretches. Every 400 requests
        // the sender holds back until the block has answered everything.
        next_pause = 400;
        while (gen_total < 1270)
        begin
            seg_kind  = $urandom_range(0, 9);
            seg_items = $urandom_range(10, 40);
            repeat (seg_items)
            begin
                roll = $urandom_range(0, 99);
                if (seg_kind < 3)           // fill toward capacity
                    op = (roll < 80) ? CMD_INSERT : CMD_GET;
                else if (seg_kind < 5)      // drain
                    op = (roll < 65) ? CMD_REMOVE : CMD_GET;
                else if (seg_kind < 9)      // mixed
                    op = (roll < 3)  ? CMD_CLEAR  :
                         (roll < 40) ? CMD_INSERT :
                         (roll < 70) ? CMD_REMOVE : CMD_GET;
                else                        // noise
                    op = cmd_t'($urandom_range(0, 3));
                if (seg_kind == 9)
                    queue_request(op, $urandom_range(0, 255) - 128, $urandom());
                else
                    queue_request(op, pick_position(), pick_word());
            end
            if (gen_total >= next_pause)
            begin
                wait_drained();
                next_pause += 400;
            end
        end

        wait_drained();
        repeat (5) @(posedge clk);
        @(negedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d responses never arrived", expected_results.size()));

        $display("Run: %0d requests (insert %0d, remove %0d, get %0d, clear %0d), %0d responses checked",
                 taken_cnt, op_seen[CMD_INSERT], op_seen[CMD_REMOVE], op_seen[CMD_GET],
                 op_seen[CMD_CLEAR], checked_cnt);
        $display("List reached %0d of %0d entries; %0d inserts hit a full list; %0d failures",
                 peak_len, CAPACITY, full_rejects, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d of %0d requests taken", taken_cnt, gen_total);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/plst_pkg.sv
design/plst_cell.sv
design/positional_list_store_unit.sv
tb/sv/tb_top.sv
